FILE: hw/rtl/xml_entity_decoder_unit_macros.svh
// Assertion macros for the entity decoder checker.
// Needs signals clk and rst in the scope where a macro is used.
`ifndef XML_ENTITY_DECODER_UNIT_MACROS_SVH
`define XML_ENTITY_DECODER_UNIT_MACROS_SVH

// check a condition on every edge outside reset
`define XED_ASSERT_NOW(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("entity decoder check failed");

// check a consequence in the cycle after an antecedent outside reset
`define XED_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("entity decoder check failed");

// check a consequence in the cycle after an antecedent, reset included
`define XED_ASSERT_AFTER(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("entity decoder check failed");

`endif

FILE: hw/rtl/xed_pkg.sv
// Shared types, constants and name tables of the entity decoder.
// No dependencies.
`default_nettype none

package xed_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned NUM_NAMES   = 5;
  localparam logic [7:0]  AMPERSAND   = 8'h26;
  localparam logic [4:0]  ALL_NAMES   = 5'h1f;

  localparam logic [2:0] NAME_QUOT = 3'd0;
  localparam logic [2:0] NAME_AMP  = 3'd1;
  localparam logic [2:0] NAME_APOS = 3'd2;
  localparam logic [2:0] NAME_LT   = 3'd3;
  localparam logic [2:0] NAME_GT   = 3'd4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
  } out_item_t;

  typedef struct packed {
    logic       flush;
    logic [1:0] plen;
    logic [2:0] pick;
    logic       tail_valid;
    logic [7:0] tail_byte;
    logic       last;
  } cmd_t;

  function automatic logic [7:0] name_text(input logic [2:0] k, input logic [1:0] i);
    logic [7:0] c;
    c = 8'h00;
    case (k)
      NAME_QUOT: begin
        case (i)
          2'd0: c = "q";
          2'd1: c = "u";
          2'd2: c = "o";
          default: c = "t";
        endcase
      end
      NAME_AMP: begin
        case (i)
          2'd0: c = "a";
          2'd1: c = "m";
          2'd2: c = "p";
          default: c = 8'h00;
        endcase
      end
      NAME_APOS: begin
        case (i)
          2'd0: c = "a";
          2'd1: c = "p";
          2'd2: c = "o";
          default: c = "s";
        endcase
      end
      NAME_LT: begin
        case (i)
          2'd0: c = "l";
          2'd1: c = "t";
          default: c = 8'h00;
        endcase
      end
      NAME_GT: begin
        case (i)
          2'd0: c = "g";
          2'd1: c = "t";
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] name_len(input logic [2:0] k);
    logic [2:0] n;
    case (k)
      NAME_QUOT: n = 3'd4;
      NAME_AMP:  n = 3'd3;
      NAME_APOS: n = 3'd4;
      NAME_LT:   n = 3'd2;
      NAME_GT:   n = 3'd2;
      default:   n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] name_char(input logic [2:0] k);
    logic [7:0] c;
    case (k)
      NAME_QUOT: c = 8'h22;
      NAME_AMP:  c = 8'h26;
      NAME_APOS: c = 8'h27;
      NAME_LT:   c = 8'h3c;
      NAME_GT:   c = 8'h3e;
      default:   c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/xed_queue.sv
// Short command queue between the front and back parts.
// Depends on xed_pkg for the command type.
`default_nettype none

module xed_queue import xed_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  wire cmd_t wr_cmd,
  output logic      full,
  input  wire logic rd_en,
  output cmd_t      rd_cmd,
  output logic      rd_valid
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_wr;
  logic            do_rd;

  assign full     = (count == CntW'(Depth));
  assign rd_valid = (count != '0);
  assign rd_cmd   = slots[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/xed_front.sv
// Front part: matches entity names and turns accepted items into commands, at most one per item.
// Depends on xed_pkg for item, command types and name tables.
`default_nettype none

module xed_front import xed_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     accept,
  input  wire in_item_t in_item,
  output logic          cmd_push,
  output cmd_t          cmd
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_MATCH,
    MODE_DROP
  } mode_t;

  mode_t      mode;
  mode_t      mode_next;
  logic [1:0] cnt;
  logic [1:0] cnt_next;
  logic [4:0] mask;
  logic [4:0] mask_next;
  logic [4:0] hit;
  logic       done;
  logic [2:0] done_idx;
  logic [7:0] b;

  function automatic logic [2:0] lowest(input logic [4:0] m);
    logic [2:0] r;
    r = '0;
    for (int k = int'(NUM_NAMES) - 1; k >= 0; k--) begin
      if (m[k]) begin
        r = 3'(k);
      end
    end
    return r;
  endfunction

  assign b = in_item.in_byte;

  always_comb begin
    hit      = '0;
    done     = 1'b0;
    done_idx = '0;
    for (int k = 0; k < int'(NUM_NAMES); k++) begin
      if (mask[k] && ({1'b0, cnt} < name_len(3'(k))) && (name_text(3'(k), cnt) == b)) begin
        hit[k] = 1'b1;
        if (({1'b0, cnt} + 3'd1 == name_len(3'(k))) && !done) begin
          done     = 1'b1;
          done_idx = 3'(k);
        end
      end
    end
  end

  always_comb begin
    mode_next      = mode;
    cnt_next       = cnt;
    mask_next      = mask;
    cmd.flush      = 1'b0;
    cmd.plen       = '0;
    cmd.pick       = '0;
    cmd.tail_valid = 1'b0;
    cmd.tail_byte  = b;
    cmd.last       = in_item.in_last;
    case (mode)
      MODE_DROP: begin
        mode_next = MODE_IDLE;
      end
      MODE_MATCH: begin
        if (done) begin
          cmd.tail_valid = 1'b1;
          cmd.tail_byte  = name_char(done_idx);
          mode_next      = MODE_DROP;
          cnt_next       = '0;
          mask_next      = '0;
        end else if (hit != '0) begin
          cnt_next  = cnt + 2'd1;
          mask_next = hit;
        end else begin
          cmd.flush = 1'b1;
          cmd.plen  = cnt;
          cmd.pick  = lowest(mask);
          if (b == AMPERSAND) begin
            mode_next = MODE_MATCH;
            cnt_next  = '0;
            mask_next = ALL_NAMES;
          end else begin
            cmd.tail_valid = 1'b1;
            mode_next      = MODE_IDLE;
            cnt_next       = '0;
            mask_next      = '0;
          end
        end
      end
      default: begin
        if (b == AMPERSAND) begin
          mode_next = MODE_MATCH;
          cnt_next  = '0;
          mask_next = ALL_NAMES;
        end else begin
          cmd.tail_valid = 1'b1;
          mode_next      = MODE_IDLE;
        end
      end
    endcase
    if (in_item.in_last) begin
      if (mode_next == MODE_MATCH) begin
        if (cmd.flush) begin
          cmd.tail_valid = 1'b1;
          cmd.tail_byte  = AMPERSAND;
        end else begin
          cmd.flush = 1'b1;
          cmd.plen  = cnt_next;
          cmd.pick  = lowest(mask_next);
        end
      end
      mode_next = MODE_IDLE;
      cnt_next  = '0;
      mask_next = '0;
    end
  end

  assign cmd_push = accept && (cmd.flush || cmd.tail_valid || cmd.last);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      cnt  <= '0;
      mask <= '0;
    end else if (accept) begin
      mode <= mode_next;
      cnt  <= cnt_next;
      mask <= mask_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/xed_back.sv
// Back part: expands each command into result items, one per cycle while the output is not stalled.
// Depends on xed_pkg for command, item types and name tables.
`default_nettype none

module xed_back import xed_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cmd_t cmd,
  input  wire logic cmd_valid,
  output logic      cmd_pop,
  output out_item_t out_item,
  output logic      empty,
  input  wire logic pop
);

  logic [2:0] step;
  logic [2:0] total;
  logic [2:0] last_idx;
  logic [1:0] step_m1;
  logic       ovalid;
  logic       load;
  out_item_t  item;

  assign total    = (cmd.flush ? 3'd1 + {1'b0, cmd.plen} : 3'd0) + {2'b0, cmd.tail_valid};
  assign last_idx = (total == 3'd0) ? 3'd0 : total - 3'd1;
  assign step_m1  = step[1:0] - 2'd1;

  always_comb begin
    if (cmd.flush && (step <= {1'b0, cmd.plen})) begin
      item.out_byte  = (step == 3'd0) ? AMPERSAND : name_text(cmd.pick, step_m1);
      item.out_valid = 1'b1;
    end else begin
      item.out_byte  = cmd.tail_valid ? cmd.tail_byte : 8'h00;
      item.out_valid = cmd.tail_valid;
    end
    item.out_last = cmd.last && (step == last_idx);
  end

  assign empty   = !ovalid;
  assign load    = cmd_valid && (!ovalid || pop);
  assign cmd_pop = load && (step == last_idx);

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      step   <= '0;
    end else begin
      if (load) begin
        ovalid <= 1'b1;
        step   <= (step == last_idx) ? 3'd0 : step + 3'd1;
      end else if (pop) begin
        ovalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/xml_entity_decoder_unit.sv
// Predefined XML entity decoder: front matcher, command queue, back expander.
// Path: an accepted item's command is written to the queue, then loaded into the output register.
// Throughput: one item per cycle while full is low; a command expands into at most five
// results in the back part, the queue absorbing the burst before full rises.
// Reset: synchronous, clears match state, queue pointers and the output valid flag.
`default_nettype none

module xml_entity_decoder_unit import xed_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire in_item_t in_item,
  input  wire logic     push,
  output logic          full,
  output out_item_t     out_item,
  output logic          empty,
  input  wire logic     pop
);

  logic accept;
  logic cmd_push;
  logic q_full;
  logic q_valid;
  logic q_pop;
  cmd_t front_cmd;
  cmd_t head_cmd;

  assign full   = q_full;
  assign accept = push && !q_full;

  xed_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_item  (in_item),
    .cmd_push (cmd_push),
    .cmd      (front_cmd)
  );

  xed_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cmd_push),
    .wr_cmd   (front_cmd),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_cmd   (head_cmd),
    .rd_valid (q_valid)
  );

  xed_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (head_cmd),
    .cmd_valid (q_valid),
    .cmd_pop   (q_pop),
    .out_item  (out_item),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/xed_checker.sv
// Port-level checks on the entity decoder, bound to the top level.
// Depends on xed_pkg and the assertion macro header.
`default_nettype none

`include "xml_entity_decoder_unit_macros.svh"

module xed_checker import xed_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      full,
  input wire out_item_t out_item,
  input wire logic      empty,
  input wire logic      pop
);

  `XED_ASSERT_AFTER(a_reset_clears, rst, empty && !full)
  `XED_ASSERT_NOW(a_marker_is_last, empty || out_item.out_valid || out_item.out_last)
  `XED_ASSERT_NOW(a_marker_is_zero, empty || out_item.out_valid || (out_item.out_byte == 8'h00))
  `XED_ASSERT_NEXT(a_stall_holds, !empty && !pop, !empty && $stable(out_item))

endmodule

bind xml_entity_decoder_unit xed_checker u_checker (.*);

`default_nettype wire

FILE: tb/tb_xml_entity_decoder_unit.sv
// Testbench for xml_entity_decoder_unit: directed and random byte strings checked
// against an in-bench decoder of the five predefined XML entities.
// Depends on xed_pkg for the item types and the name constants.
module tb_xml_entity_decoder_unit;
  import xed_pkg::*;

  localparam int CYCLE_LIMIT = 100000;

  typedef enum logic [1:0] {
    DEC_IDLE  = 2'd0,
    DEC_MATCH = 2'd1,
    DEC_DROP  = 2'd2
  } dec_mode_t;

  typedef enum int {
    RX_READY,
    RX_RANDOM,
    RX_PATTERN
  } rx_style_t;

  logic      clk     = 1'b0;
  logic      rst     = 1'b1;
  in_item_t  in_item = '0;
  logic      push    = 1'b0;
  logic      full;
  out_item_t out_item;
  logic      empty;
  logic      pop     = 1'b0;

  logic [7:0] ent_text [5][4] = '{'{"q", "u", "o", "t"}, '{"a", "m", "p", 8'h00},
                                  '{"a", "p", "o", "s"}, '{"l", "t", 8'h00, 8'h00},
                                  '{"g", "t", 8'h00, 8'h00}};
  int         ent_len  [5]    = '{4, 3, 4, 2, 2};
  logic [7:0] ent_char [5]    = '{8'h22, 8'h26, 8'h27, 8'h3c, 8'h3e};

  dec_mode_t  dec_mode  = DEC_IDLE;
  logic [2:0] match_cnt = '0;
  logic [4:0] cand      = '0;

  out_item_t  expected_chars[$];
  logic [7:0] line_buf[$];

  int        fails      = 0;
  int        cycle_cnt  = 0;
  rx_style_t rx_style   = RX_READY;
  bit        gaps_on    = 1'b0;
  int        burst_left = 0;
  int        hold_len   = 0;
  bit        hold_go    = 1'b0;
  bit        hold_ack   = 1'b0;
  int        hold_left  = 0;
  int        pat_idx    = 0;
  logic [7:0] stall_pat = 8'b1011_0110;

  xml_entity_decoder_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_item),
    .push     (push),
    .full     (full),
    .out_item (out_item),
    .empty    (empty),
    .pop      (pop)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic void push_char(input logic [7:0] b);
    expected_chars.push_back('{out_byte: b, out_valid: 1'b1, out_last: 1'b0});
  endfunction

  function automatic void flush_prefix();
    int pick;
    pick = 0;
    for (int k = 4; k >= 0; k--)
      if (cand[k]) pick = k;
    push_char(AMPERSAND);
    for (int i = 0; i < match_cnt && i < ent_len[pick]; i++)
      push_char(ent_text[pick][i]);
    dec_mode  = DEC_IDLE;
    match_cnt = '0;
    cand      = '0;
  endfunction

  function automatic void decode_fresh(input logic [7:0] b);
    if (b == AMPERSAND) begin
      dec_mode  = DEC_MATCH;
      match_cnt = '0;
      cand      = ALL_NAMES;
    end else begin
      push_char(b);
    end
  endfunction

  function automatic void decode_item(input in_item_t it);
    int         base;
    int         hit;
    logic [4:0] nxt;
    out_item_t  tail;
    base = expected_chars.size();
    if (dec_mode == DEC_DROP) begin
      dec_mode = DEC_IDLE;
    end else if (dec_mode == DEC_MATCH) begin
      nxt = '0;
      hit = -1;
      for (int k = 0; k < 5; k++) begin
        if (cand[k] && match_cnt < ent_len[k] && ent_text[k][match_cnt[1:0]] == it.in_byte) begin
          nxt[k] = 1'b1;
          if (match_cnt + 1 == ent_len[k] && hit < 0) hit = k;
        end
      end
      if (hit >= 0) begin
        push_char(ent_char[hit]);
        dec_mode  = DEC_DROP;
        match_cnt = '0;
        cand      = '0;
      end else if (nxt != '0) begin
        match_cnt = match_cnt + 3'd1;
        cand      = nxt;
      end else begin
        flush_prefix();
        decode_fresh(it.in_byte);
      end
    end else begin
      dec_mode = DEC_IDLE;
      decode_fresh(it.in_byte);
    end
    if (it.in_last) begin
      if (dec_mode == DEC_MATCH) flush_prefix();
      dec_mode  = DEC_IDLE;
      match_cnt = '0;
      cand      = '0;
      if (expected_chars.size() == base) begin
        expected_chars.push_back('{out_byte: 8'h00, out_valid: 1'b0, out_last: 1'b1});
      end else begin
        tail = expected_chars[expected_chars.size() - 1];
        tail.out_last = 1'b1;
        expected_chars[expected_chars.size() - 1] = tail;
      end
    end
  endfunction

  always @(negedge clk) begin
    if (hold_go != hold_ack) begin
      hold_ack  = hold_go;
      hold_left = hold_len;
    end
    if (rst || hold_left != 0) begin
      if (hold_left != 0) hold_left--;
      pop <= 1'b0;
    end else begin
      case (rx_style)
        RX_READY:  pop <= 1'b1;
        RX_RANDOM: pop <= ($urandom_range(0, 2) != 0);
        default:   pop <= stall_pat[pat_idx % 8];
      endcase
    end
    pat_idx++;
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && pop && !empty) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected item: out_byte %h out_valid %b out_last %b",
               out_item.out_byte, out_item.out_valid, out_item.out_last);
        fails++;
      end else begin
        want = expected_chars.pop_front();
        if (out_item.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, got %h", want.out_byte, out_item.out_byte);
          fails++;
        end
        if (out_item.out_valid !== want.out_valid) begin
          $error("out_valid: expected %b, got %b", want.out_valid, out_item.out_valid);
          fails++;
        end
        if (out_item.out_last !== want.out_last) begin
          $error("out_last: expected %b, got %b", want.out_last, out_item.out_last);
          fails++;
        end
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic l);
    @(negedge clk);
    push    <= 1'b1;
    in_item <= '{in_byte: b, in_last: l};
    do @(posedge clk); while (full);
    decode_item('{in_byte: b, in_last: l});
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
        @(negedge clk);
        push <= 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++)
      send_item(line_buf[i], i == line_buf.size() - 1);
    line_buf.delete();
  endtask

  task automatic load_str(input string s);
    for (int i = 0; i < s.len(); i++)
      line_buf.push_back(s[i]);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    push <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
  endtask

  task automatic build_random_line();
    int         tokens;
    int         sel;
    int         k;
    int         n;
    logic [7:0] rb;
    tokens = $urandom_range(1, 5);
    repeat (tokens) begin
      sel = $urandom_range(0, 9);
      rb  = $urandom_range(0, 255);
      if (sel < 5) begin
        line_buf.push_back(AMPERSAND);
        for (int i = 0; i < ent_len[sel]; i++) line_buf.push_back(ent_text[sel][i]);
        line_buf.push_back($urandom_range(0, 1) ? 8'h3b : rb);
      end else if (sel == 5) begin
        k = $urandom_range(0, 4);
        n = $urandom_range(0, ent_len[k] - 1);
        line_buf.push_back(AMPERSAND);
        for (int i = 0; i < n; i++) line_buf.push_back(ent_text[k][i]);
        line_buf.push_back(rb);
      end else if (sel < 8) begin
        line_buf.push_back(rb);
      end else if (sel == 8) begin
        line_buf.push_back(8'($urandom_range(97, 122)));
      end else begin
        line_buf.push_back(AMPERSAND);
      end
    end
  endtask

  task automatic test_entity_names();
    rx_style = RX_READY;
    gaps_on  = 1'b0;
    load_str("&lt&&gt");
    line_buf.push_back(8'h00);
    load_str("&amp");
    line_buf.push_back(8'hff);
    load_str("&quot");
    send_line();
  endtask

  task automatic test_mismatch_and_flush();
    rx_style = RX_RANDOM;
    gaps_on  = 1'b1;
    load_str("&aq&apo&apos;");
    send_line();
    load_str("&am");
    send_line();
  endtask

  task automatic test_random_traffic(input int n_items, input rx_style_t style);
    int sent;
    sent     = 0;
    rx_style = style;
    gaps_on  = 1'b1;
    while (sent < n_items) begin
      build_random_line();
      sent += line_buf.size();
      send_line();
    end
  endtask

  task automatic test_backpressure();
    int sent;
    sent     = 0;
    rx_style = RX_READY;
    gaps_on  = 1'b0;
    hold_len = 120;
    hold_go  = ~hold_go;
    while (sent < 30) begin
      build_random_line();
      sent += line_buf.size();
      send_line();
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    test_entity_names();
    wait_drained();
    test_mismatch_and_flush();
    wait_drained();
    test_random_traffic(60, RX_RANDOM);
    wait_drained();
    test_backpressure();
    wait_drained();
    test_random_traffic(50, RX_PATTERN);
    wait_drained();
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
